// ===== src/dele_pkg.sv =====
package dele_pkg;

    localparam int DEF_CAPACITY = 16;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int ECOUNT_W = 5;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH_HEAD = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_TAIL = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_HEAD  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_TAIL  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DELETE    = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // requests to the free-slot map
    typedef struct packed {
        logic take;
        logic give;
    } t_free_req;

endpackage

// ===== src/dele_free_map.sv =====
module dele_free_map #(
    parameter int CAPACITY = dele_pkg::DEF_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dele_pkg::t_free_req         i_req,
    input  logic [$clog2(CAPACITY)-1:0] i_take_slot,
    input  logic [$clog2(CAPACITY)-1:0] i_give_slot,
    output logic [$clog2(CAPACITY)-1:0] o_alloc_slot,
    output logic                        o_any_free
);

    localparam int SW = $clog2(CAPACITY);

    logic [CAPACITY-1:0] r_free;
    logic [SW-1:0]       r_alloc_slot;
    logic                r_any_free;
    logic [SW-1:0]       n_alloc_slot;
    logic                n_any_free;

    // lowest free slot, registered so it follows the map in the cycle after
    always_comb begin
        n_alloc_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                n_alloc_slot = SW'(i);
            end
        end
        n_any_free = |r_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free       <= '1;
            r_alloc_slot <= '0;
            r_any_free   <= 1'b1;
        end else begin
            r_alloc_slot <= n_alloc_slot;
            r_any_free   <= n_any_free;
            if (i_req.take) begin
                r_free[i_take_slot] <= 1'b0;
            end
            if (i_req.give) begin
                r_free[i_give_slot] <= 1'b1;
            end
        end
    end

    assign o_alloc_slot = r_alloc_slot;
    assign o_any_free   = r_any_free;

    a_take_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.take |-> r_free[i_take_slot])
        else $error("slot taken that is not free");

    a_give_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.give |-> !r_free[i_give_slot])
        else $error("slot released that is already free");

    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.take && i_req.give))
        else $error("take and release in the same cycle");

    a_any_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.take |=> (r_any_free == ($past(r_free) != '0)))
        else $error("free flag does not follow the map");

endmodule

// ===== src/double_ended_list_engine.sv =====
// channel   dir  handshake                  payload
// --------  ---  -------------------------  ----------------------------------------
// request   in   i_in_valid / o_in_ready    i_func, i_value
// result    out  o_out_valid / i_out_ready  o_status, o_removed_value, o_entry_count
//
// route per request: an empty pop, a delete on an empty list or an unknown code goes straight
// to S_RESULT; a pop passes S_READ, a push S_PUSH, and a push into a non-empty list with room also S_LINK
// delete reads one node per cycle from the head in S_WALK, then S_READ and, for a middle node, S_FIX
// reset (i_rst_n low, synchronous) frees every slot and empties the list; node memories keep
// their contents; a result held by i_out_ready low stalls the engine in S_RESULT and a new
// request is taken only once the previous result sits in the output register
module double_ended_list_engine #(
    parameter int CAPACITY = dele_pkg::DEF_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [dele_pkg::FUNC_W-1:0]         i_func,
    input  logic signed [dele_pkg::VALUE_W-1:0] i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [dele_pkg::STATUS_W-1:0]       o_status,
    output logic signed [dele_pkg::VALUE_W-1:0] o_removed_value,
    output logic [dele_pkg::ECOUNT_W-1:0]       o_entry_count
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic [SW-1:0] nxt;
        logic [SW-1:0] prv;
    } t_link;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PUSH   = 7'b0000010,
        S_LINK   = 7'b0000100,
        S_WALK   = 7'b0001000,
        S_READ   = 7'b0010000,
        S_FIX    = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

    // node memories
    logic [dele_pkg::VALUE_W-1:0] r_val_mem  [CAPACITY];
    t_link                        r_link_mem [CAPACITY];
    logic [dele_pkg::VALUE_W-1:0] r_rd_val;
    t_link                        r_rd_link;

    logic                         rd_en;
    logic [SW-1:0]                rd_addr;
    logic                         val_we;
    logic                         link_we_nxt;
    logic                         link_we_prv;
    logic [SW-1:0]                link_wa;
    t_link                        link_wd;

    // free map
    dele_pkg::t_free_req          free_req;
    logic [SW-1:0]                alloc_slot;
    logic                         alloc_any;

    t_state                          r_state,   n_state;
    logic [dele_pkg::FUNC_W-1:0]     r_func,    n_func;
    logic [dele_pkg::VALUE_W-1:0]    r_val,     n_val;
    logic [SW-1:0]                   r_slot,    n_slot;
    logic [SW-1:0]                   r_head,    n_head;
    logic [SW-1:0]                   r_tail,    n_tail;
    logic [CW-1:0]                   r_count,   n_count;
    logic [CW-1:0]                   r_left,    n_left;
    logic [dele_pkg::STATUS_W-1:0]   r_status,  n_status;
    logic [dele_pkg::VALUE_W-1:0]    r_removed, n_removed;
    logic                            r_o_valid, n_o_valid;
    logic [dele_pkg::STATUS_W-1:0]   r_o_status,  n_o_status;
    logic [dele_pkg::VALUE_W-1:0]    r_o_removed, n_o_removed;
    logic [dele_pkg::ECOUNT_W-1:0]   r_o_count,   n_o_count;

    logic fix_next;
    logic fix_prev;
    logic is_push_head;

    dele_free_map #(
        .CAPACITY (CAPACITY)
    ) u_free_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (free_req),
        .i_take_slot  (alloc_slot),
        .i_give_slot  (r_slot),
        .o_alloc_slot (alloc_slot),
        .o_any_free   (alloc_any)
    );

    assign o_in_ready   = (r_state == S_IDLE);
    assign is_push_head = (r_func == dele_pkg::FUNC_PUSH_HEAD);
    assign fix_next     = (r_slot != r_head);
    assign fix_prev     = (r_slot != r_tail);

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_val       = r_val;
        n_slot      = r_slot;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_left      = r_left;
        n_status    = r_status;
        n_removed   = r_removed;
        n_o_valid   = r_o_valid && !i_out_ready;
        n_o_status  = r_o_status;
        n_o_removed = r_o_removed;
        n_o_count   = r_o_count;
        rd_en       = 1'b0;
        rd_addr     = r_head;
        val_we      = 1'b0;
        link_we_nxt = 1'b0;
        link_we_prv = 1'b0;
        link_wa     = r_slot;
        link_wd     = '0;
        free_req    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func    = i_func;
                    n_val     = i_value;
                    n_status  = dele_pkg::ST_OK;
                    n_removed = '0;
                    priority if (i_func == dele_pkg::FUNC_PUSH_HEAD ||
                                 i_func == dele_pkg::FUNC_PUSH_TAIL) begin
                        n_state = S_PUSH;
                    end else if (i_func == dele_pkg::FUNC_POP_HEAD ||
                                 i_func == dele_pkg::FUNC_POP_TAIL) begin
                        if (r_count == '0) begin
                            n_status = dele_pkg::ST_EMPTY;
                            n_state  = S_RESULT;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = (i_func == dele_pkg::FUNC_POP_HEAD) ? r_head : r_tail;
                            n_slot  = rd_addr;
                            n_state = S_READ;
                        end
                    end else if (i_func == dele_pkg::FUNC_DELETE) begin
                        if (r_count == '0) begin
                            n_status = dele_pkg::ST_NOTFOUND;
                            n_state  = S_RESULT;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_head;
                            n_slot  = r_head;
                            n_left  = CW'(r_count - 1'b1);
                            n_state = S_WALK;
                        end
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end

            S_PUSH: begin
                if (!alloc_any) begin
                    n_status = dele_pkg::ST_FULL;
                    n_state  = S_RESULT;
                end else begin
                    val_we        = 1'b1;
                    free_req.take = 1'b1;
                    n_count       = CW'(r_count + 1'b1);
                    link_wa       = alloc_slot;
                    if (r_count == '0) begin
                        n_head  = alloc_slot;
                        n_tail  = alloc_slot;
                        n_state = S_RESULT;
                    end else begin
                        n_slot = alloc_slot;
                        if (is_push_head) begin
                            link_we_nxt = 1'b1;
                            link_wd.nxt = r_head;
                        end else begin
                            link_we_prv = 1'b1;
                            link_wd.prv = r_tail;
                        end
                        n_state = S_LINK;
                    end
                end
            end

            S_LINK: begin
                // link from the old end node to the new one: prv of the old head or nxt of the old tail
                if (is_push_head) begin
                    link_wa     = r_head;
                    link_we_prv = 1'b1;
                    link_wd.prv = r_slot;
                    n_head      = r_slot;
                end else begin
                    link_wa     = r_tail;
                    link_we_nxt = 1'b1;
                    link_wd.nxt = r_slot;
                    n_tail      = r_slot;
                end
                n_state = S_RESULT;
            end

            S_WALK: begin
                // read data belongs to r_slot; next address comes straight from it
                if (r_rd_val == r_val) begin
                    n_state = S_READ;
                end else if (r_left == '0) begin
                    n_status = dele_pkg::ST_NOTFOUND;
                    n_state  = S_RESULT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_rd_link.nxt;
                    n_slot  = r_rd_link.nxt;
                    n_left  = CW'(r_left - 1'b1);
                end
            end

            S_READ: begin
                // unlink r_slot using the node read last
                n_removed     = r_rd_val;
                free_req.give = 1'b1;
                n_count       = CW'(r_count - 1'b1);
                n_state       = S_RESULT;
                if (r_count == CW'(1)) begin
                    n_head = '0;
                    n_tail = '0;
                end else begin
                    if (!fix_next) begin
                        n_head = r_rd_link.nxt;
                    end
                    if (!fix_prev) begin
                        n_tail = r_rd_link.prv;
                    end
                    if (fix_next) begin
                        link_wa     = r_rd_link.prv;
                        link_we_nxt = 1'b1;
                        link_wd.nxt = r_rd_link.nxt;
                        if (fix_prev) begin
                            n_state = S_FIX;
                        end
                    end else if (fix_prev) begin
                        link_wa     = r_rd_link.nxt;
                        link_we_prv = 1'b1;
                        link_wd.prv = r_rd_link.prv;
                    end
                end
            end

            S_FIX: begin
                link_wa     = r_rd_link.nxt;
                link_we_prv = 1'b1;
                link_wd.prv = r_rd_link.prv;
                n_state     = S_RESULT;
            end

            S_RESULT: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid   = 1'b1;
                    n_o_status  = r_status;
                    n_o_removed = r_removed;
                    n_o_count   = dele_pkg::ECOUNT_W'(r_count);
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // node memories; reads and writes never fall in the same cycle since every
    // request finishes its writes before the next one issues a read
    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_val_mem[alloc_slot] <= r_val;
        end
        if (link_we_nxt) begin
            r_link_mem[link_wa].nxt <= link_wd.nxt;
        end
        if (link_we_prv) begin
            r_link_mem[link_wa].prv <= link_wd.prv;
        end
        if (rd_en) begin
            r_rd_val  <= r_val_mem[rd_addr];
            r_rd_link <= r_link_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_val       <= n_val;
        r_slot      <= n_slot;
        r_left      <= n_left;
        r_status    <= n_status;
        r_removed   <= n_removed;
        r_o_status  <= n_o_status;
        r_o_removed <= n_o_removed;
        r_o_count   <= n_o_count;
    end

    assign o_out_valid     = r_o_valid;
    assign o_status        = r_o_status;
    assign o_removed_value = r_o_removed;
    assign o_entry_count   = r_o_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list count above capacity");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |-> (alloc_any == (r_count != CW'(CAPACITY))))
        else $error("free map disagrees with list count");

    a_walk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_left < r_count))
        else $error("walk runs past the list length");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && r_o_valid && !i_out_ready) |=> (r_state == S_RESULT))
        else $error("result dropped while output register busy");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int CAPACITY = dele_pkg::DEF_CAPACITY;
    localparam int FUNC_W   = dele_pkg::FUNC_W;
    localparam int VALUE_W  = dele_pkg::VALUE_W;
    localparam int STATUS_W = dele_pkg::STATUS_W;
    localparam int ECOUNT_W = dele_pkg::ECOUNT_W;
    localparam int LIMIT = 400_000;
    localparam int PHASES = 15;
    localparam int PHASE_ITEMS = 100;

    // codes the engine ignores
    localparam logic [FUNC_W-1:0] FUNC_RESERVED_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RESERVED_LAST  = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] removed;
        logic [ECOUNT_W-1:0]       count;
    } t_list_result;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] value;
        logic                      typed;
        t_list_result              expected;
    } t_request_row;

    typedef enum int {PH_FILL, PH_HUNT, PH_DRAIN, PH_MIXED} t_phase_kind;

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [FUNC_W-1:0]          i_func = '0;
    logic signed [VALUE_W-1:0]  i_value = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [STATUS_W-1:0]        o_status;
    logic signed [VALUE_W-1:0]  o_removed_value;
    logic [ECOUNT_W-1:0]        o_entry_count;

    // list contents from head to tail, as the engine should hold them
    logic signed [VALUE_W-1:0]  list_contents[$];
    t_list_result               pending_results[$];
    t_request_row               directed_rows[20];

    int unsigned error_count = 0;
    int unsigned requests_sent = 0;
    int unsigned results_checked = 0;
    int unsigned status_hits[4] = '{default: 0};
    int unsigned cycle_count = 0;

    double_ended_list_engine #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_func(i_func),
        .i_value(i_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_removed_value(o_removed_value),
        .o_entry_count(o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** double_ended_list_engine: FAILED **");
        $finish;
    end

    function automatic t_list_result apply_list_op(logic [FUNC_W-1:0] func,
                                                   logic signed [VALUE_W-1:0] value);
        t_list_result res;
        int hit;
        res = '0;
        hit = -1;
        case (func)
            dele_pkg::FUNC_PUSH_HEAD, dele_pkg::FUNC_PUSH_TAIL: begin
                if (list_contents.size() >= CAPACITY)
                    res.status = dele_pkg::ST_FULL;
                else if (func == dele_pkg::FUNC_PUSH_HEAD)
                    list_contents.push_front(value);
                else
                    list_contents.push_back(value);
            end
            dele_pkg::FUNC_POP_HEAD, dele_pkg::FUNC_POP_TAIL: begin
                if (list_contents.size() == 0)
                    res.status = dele_pkg::ST_EMPTY;
                else if (func == dele_pkg::FUNC_POP_HEAD)
                    res.removed = list_contents.pop_front();
                else
                    res.removed = list_contents.pop_back();
            end
            dele_pkg::FUNC_DELETE: begin
                // first match counted from the head
                for (int i = 0; i < list_contents.size(); i++) begin
                    if (list_contents[i] == value) begin
                        hit = i;
                        break;
                    end
                end
                if (hit < 0) begin
                    res.status = dele_pkg::ST_NOTFOUND;
                end else begin
                    res.removed = list_contents[hit];
                    list_contents.delete(hit);
                end
            end
            default: ;
        endcase
        res.count = ECOUNT_W'(list_contents.size());
        return res;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            // narrow pool so duplicates and delete hits are common
            v = $urandom_range(0, 7);
            v = v - 4;
        end else if (r < 70) begin
            case ($urandom_range(0, 3))
                0: v = 32'sh7FFF_FFFF;
                1: v = 32'sh8000_0000;
                2: v = 32'sd0;
                default: v = -32'sd1;
            endcase
        end else begin
            v = $urandom();
        end
        return v;
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func(t_phase_kind kind);
        int unsigned r;
        int unsigned push_pct;
        int unsigned pop_pct;
        case (kind)
            PH_FILL:  begin push_pct = 75; pop_pct = 10; end
            PH_HUNT:  begin push_pct = 35; pop_pct = 10; end
            PH_DRAIN: begin push_pct = 10; pop_pct = 70; end
            default:  begin push_pct = 40; pop_pct = 35; end
        endcase
        r = $urandom_range(0, 99);
        if (r >= 97)
            return FUNC_W'($urandom_range(FUNC_RESERVED_FIRST, FUNC_RESERVED_LAST));
        if (r < push_pct)
            return $urandom_range(0, 1) ? dele_pkg::FUNC_PUSH_TAIL : dele_pkg::FUNC_PUSH_HEAD;
        if (r < push_pct + pop_pct)
            return $urandom_range(0, 1) ? dele_pkg::FUNC_POP_TAIL : dele_pkg::FUNC_POP_HEAD;
        return dele_pkg::FUNC_DELETE;
    endfunction

    // called at a rising edge; returns at the edge of the request transfer
    task automatic send_request(input logic [FUNC_W-1:0] func,
                                input logic signed [VALUE_W-1:0] value,
                                input int unsigned gap,
                                input logic typed,
                                input t_list_result typed_result);
        t_list_result predicted;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= func;
        i_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_list_op(func, value);
        if (typed)
            predicted = typed_result;
        pending_results.push_back(predicted);
        status_hits[predicted.status]++;
        requests_sent++;
    endtask

    // result side: random stall before each transfer, with stretches of none
    initial begin
        int unsigned stall;
        bit eager;
        eager = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0)
                eager = !eager;
            stall = eager ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: status %0d removed %0d count %0d",
                       o_status, o_removed_value, o_entry_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_removed_value !== want.removed) begin
                    $error("removed_value: expected %0d, got %0d", want.removed,
                           o_removed_value);
                    error_count++;
                end
                if (o_entry_count !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, o_entry_count);
                    error_count++;
                end
            end
        end
    end

    initial begin
        logic [FUNC_W-1:0] func;
        logic signed [VALUE_W-1:0] value;
        int unsigned gap;
        bit eager_send;
        t_phase_kind kind;

        directed_rows = '{
            '{dele_pkg::FUNC_POP_HEAD,  32'sd0,         1'b1,
              '{dele_pkg::ST_EMPTY,    32'sd0, 5'd0}},
            '{dele_pkg::FUNC_POP_TAIL,  32'sd0,         1'b1,
              '{dele_pkg::ST_EMPTY,    32'sd0, 5'd0}},
            '{dele_pkg::FUNC_DELETE,    32'sd0,         1'b1,
              '{dele_pkg::ST_NOTFOUND, 32'sd0, 5'd0}},
            '{FUNC_RESERVED_FIRST,      32'sd0,         1'b1,
              '{dele_pkg::ST_OK,       32'sd0, 5'd0}},
            '{dele_pkg::FUNC_PUSH_HEAD, 32'sh7FFF_FFFF, 1'b1,
              '{dele_pkg::ST_OK,       32'sd0, 5'd1}},
            '{dele_pkg::FUNC_PUSH_TAIL, 32'sh8000_0000, 1'b1,
              '{dele_pkg::ST_OK,       32'sd0, 5'd2}},
            '{dele_pkg::FUNC_PUSH_HEAD, -32'sd1,        1'b1,
              '{dele_pkg::ST_OK,       32'sd0, 5'd3}},
            '{dele_pkg::FUNC_PUSH_TAIL, 32'sd0,         1'b1,
              '{dele_pkg::ST_OK,       32'sd0, 5'd4}},
            '{dele_pkg::FUNC_DELETE,    32'sd12345,     1'b1,
              '{dele_pkg::ST_NOTFOUND, 32'sd0, 5'd4}},
            '{FUNC_RESERVED_LAST,       32'sh7FFF_FFFF, 1'b1,
              '{dele_pkg::ST_OK,       32'sd0, 5'd4}},
            // delete from the middle, then both ends
            '{dele_pkg::FUNC_DELETE,    32'sh8000_0000, 1'b0, '0},
            '{dele_pkg::FUNC_POP_TAIL,  32'sd0,         1'b0, '0},
            '{dele_pkg::FUNC_POP_HEAD,  32'sd0,         1'b0, '0},
            '{dele_pkg::FUNC_PUSH_TAIL, 32'sd5,         1'b0, '0},
            '{dele_pkg::FUNC_PUSH_HEAD, 32'sd5,         1'b0, '0},
            '{dele_pkg::FUNC_DELETE,    32'sd5,         1'b0, '0},
            '{dele_pkg::FUNC_DELETE,    32'sh7FFF_FFFF, 1'b0, '0},
            // the only node left
            '{dele_pkg::FUNC_DELETE,    32'sd5,         1'b0, '0},
            '{dele_pkg::FUNC_POP_HEAD,  32'sd0,         1'b1,
              '{dele_pkg::ST_EMPTY,    32'sd0, 5'd0}},
            '{dele_pkg::FUNC_PUSH_TAIL, 32'sd42,        1'b0, '0}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            send_request(directed_rows[r].func, directed_rows[r].value,
                         $urandom_range(0, 9), directed_rows[r].typed,
                         directed_rows[r].expected);

        // phases rotate fill, delete hunting, drain and mixed traffic
        for (int phase = 0; phase < PHASES; phase++) begin
            kind = t_phase_kind'(phase % 4);
            eager_send = ($urandom_range(0, 2) == 0);
            repeat (PHASE_ITEMS) begin
                func = pick_func(kind);
                value = pick_value();
                if (func == dele_pkg::FUNC_DELETE && list_contents.size() > 0
                    && $urandom_range(0, 1))
                    value = list_contents[$urandom_range(0, list_contents.size() - 1)];
                gap = eager_send ? 0 : $urandom_range(0, 9);
                send_request(func, value, gap, 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        // catch any stray result after the last one
        repeat (CAPACITY + 8) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked", requests_sent, results_checked);
        $display("full pool refused %0d times, empty pops %0d, unmatched deletes %0d",
                 status_hits[dele_pkg::ST_FULL], status_hits[dele_pkg::ST_EMPTY],
                 status_hits[dele_pkg::ST_NOTFOUND]);
        if (error_count == 0)
            $display("** double_ended_list_engine: PASSED **");
        else
            $display("** double_ended_list_engine: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
src/dele_pkg.sv
src/dele_free_map.sv
src/double_ended_list_engine.sv
verif/testbench.sv
